/* src/apjb_pkg.sv */
package apjb_pkg;

  localparam int OP_W    = 2;
  localparam int SMP_W   = 16;
  localparam int LEN_W   = 16;
  localparam int TGT_W   = 13;
  localparam int FILL_W  = 13;
  localparam int CNT_W   = 32;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [31:0] LCG_MUL = 32'd1664525;
  localparam logic [31:0] LCG_ADD = 32'd1013904223;

  // x mod 41 via floor(2^37/41); quotient estimate is low by at most one
  localparam logic [31:0] RECIP       = 32'd3352169596;
  localparam int          RECIP_SHIFT = 37;
  localparam int          RES_W       = 7;
  localparam int          NOISE_MOD   = 41;
  localparam int          NOISE_OFS   = 20;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_MEM,
    SRC_NOISE
  } src_t;

  typedef struct packed {
    src_t              src;
    logic              ok;
    logic [FILL_W-1:0] fill;
    logic [CNT_W-1:0]  ovr;
    logic [CNT_W-1:0]  und;
    logic [31:0]       noise;
  } meta_t;

endpackage

/* src/apjb_cmd_if.sv */
interface apjb_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [apjb_pkg::OP_W-1:0]        operation;
  logic signed [apjb_pkg::SMP_W-1:0] sample;
  logic                             burst_start;
  logic [apjb_pkg::LEN_W-1:0]       burst_length;

  modport source (output valid, operation, sample, burst_start, burst_length, input ready);
  modport sink (input valid, operation, sample, burst_start, burst_length, output ready);
endinterface

/* src/apjb_res_if.sv */
interface apjb_res_if;
  logic                              valid;
  logic                              ready;
  logic signed [apjb_pkg::SMP_W-1:0] read_sample;
  logic                              burst_ok;
  logic [apjb_pkg::FILL_W-1:0]       fill_level;
  logic [apjb_pkg::CNT_W-1:0]        overrun_total;
  logic [apjb_pkg::CNT_W-1:0]        underrun_total;

  modport source (output valid, read_sample, burst_ok, fill_level, overrun_total,
                  underrun_total, input ready);
  modport sink (input valid, read_sample, burst_ok, fill_level, overrun_total,
                underrun_total, output ready);
endinterface

/* src/audio_playout_jitter_buffer_unit.sv */
// Audio playout jitter buffer.
// cmd channel: one request per sample: write, read or clear, with burst_start
// and burst_length on the first item of a write or read burst.
// res channel: exactly one result per request, in order: popped sample or
// comfort noise on read (0 otherwise), burst_ok, fill level after the request
// and the overrun / underrun totals.
// APB port: register 0 (byte address 0) is target_depth, the level the read
// burst drain steers toward. pready is tied high.
// Throughput: one request per cycle unless res stalls. Every request updates
// pointers and counters in its accept cycle, using the single store port once at most.
// Pipeline: three register stages (store read, reciprocal multiply for the
// noise residue, output register); res.valid rises once the item reaches the
// output register.
// Reset clears pointers, fill, counters, noise state and target_depth; store
// contents are not cleared and are only read after being written.
// A stalled receiver holds the result; cmd.ready stays high until all three
// result stages are occupied.
module audio_playout_jitter_buffer_unit #(
  parameter int CAPACITY = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [apjb_pkg::PADDR_W-1:0] paddr,
  input  logic [apjb_pkg::PDATA_W-1:0] pwdata,
  output logic [apjb_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  apjb_cmd_if.sink                     cmd,
  apjb_res_if.source                   res
);

  localparam int IW = $clog2(CAPACITY);

  logic [apjb_pkg::TGT_W-1:0] target_depth;
  logic                       reg_sel, acc, take;
  logic                       mem_en, mem_we;
  logic [IW-1:0]              mem_addr;
  logic [apjb_pkg::SMP_W-1:0] mem_wdata, mem_q;
  apjb_pkg::meta_t            meta;

  assign pready  = 1'b1;
  assign reg_sel = !paddr[2];
  assign prdata  = reg_sel ? apjb_pkg::PDATA_W'(target_depth) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_depth <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      target_depth <= pwdata[apjb_pkg::TGT_W-1:0];
    end
  end

  assign cmd.ready = take;
  assign acc       = cmd.valid && take;

  apjb_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .acc          (acc),
    .operation    (cmd.operation),
    .sample       (cmd.sample),
    .burst_start  (cmd.burst_start),
    .burst_length (cmd.burst_length),
    .target_depth (target_depth),
    .mem_en       (mem_en),
    .mem_we       (mem_we),
    .mem_addr     (mem_addr),
    .mem_wdata    (mem_wdata),
    .meta         (meta)
  );

  apjb_store #(.DEPTH(CAPACITY)) u_store (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .q     (mem_q)
  );

  apjb_resp u_resp (
    .clk  (clk),
    .rst  (rst),
    .acc  (acc),
    .meta (meta),
    .q    (mem_q),
    .take (take),
    .res  (res)
  );

endmodule

/* src/apjb_store.sv */
module apjb_store #(
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic                       we,
  input  logic [AW-1:0]              addr,
  input  logic [apjb_pkg::SMP_W-1:0] wdata,
  output logic [apjb_pkg::SMP_W-1:0] q
);

  logic [apjb_pkg::SMP_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en && we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (en && !we) begin
      q <= mem[addr];
    end
  end

endmodule

/* src/apjb_ctrl.sv */
module apjb_ctrl #(
  parameter int CAPACITY = 4096,
  localparam int IW = $clog2(CAPACITY)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        acc,
  input  logic [apjb_pkg::OP_W-1:0]   operation,
  input  logic [apjb_pkg::SMP_W-1:0]  sample,
  input  logic                        burst_start,
  input  logic [apjb_pkg::LEN_W-1:0]  burst_length,
  input  logic [apjb_pkg::TGT_W-1:0]  target_depth,
  output logic                        mem_en,
  output logic                        mem_we,
  output logic [IW-1:0]               mem_addr,
  output logic [apjb_pkg::SMP_W-1:0]  mem_wdata,
  output apjb_pkg::meta_t             meta
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = ((CW > apjb_pkg::LEN_W) ? CW : apjb_pkg::LEN_W) + 2;
  localparam int EW = (CW > apjb_pkg::FILL_W) ? CW : apjb_pkg::FILL_W;

  logic [IW-1:0]             rd_idx, wr_idx;
  logic [CW-1:0]             count;
  logic [apjb_pkg::CNT_W-1:0] ovr, und;
  logic [31:0]               noise;
  logic                      bu;

  logic [IW-1:0]              rd_idx_next, wr_idx_next, rd_base;
  logic [XW-1:0]              cnt_next, cnt_base;
  logic [apjb_pkg::CNT_W-1:0] ovr_next, und_next;
  logic [31:0]                noise_next;
  logic                       bu_next, under;

  logic [XW-1:0] fill_x, len_x, tgt_x, cap_x, thr, excess, drop;
  logic [XW-1:0] rd_sum, rd_drained, cnt_drained, len_c;
  logic          len_nz, drain, ov_a, ov_b, chk;
  logic [EW-1:0] fill_ext;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] i);
    return (i == IW'(CAPACITY - 1)) ? '0 : i + IW'(1);
  endfunction

  always_comb begin
    fill_x      = XW'(count);
    len_x       = XW'(burst_length);
    tgt_x       = XW'(target_depth);
    cap_x       = XW'(CAPACITY);
    len_nz      = burst_length != '0;
    chk         = burst_start && len_nz;
    thr         = tgt_x + (len_x << 1);
    excess      = fill_x - tgt_x - len_x;
    drain       = fill_x > thr;
    drop        = drain ? ((excess < len_x) ? excess : len_x) : '0;
    rd_sum      = XW'(rd_idx) + drop;
    rd_drained  = (rd_sum >= cap_x) ? rd_sum - cap_x : rd_sum;
    cnt_drained = fill_x - drop;
    len_c       = (len_x > cap_x) ? cap_x : len_x;
    ov_a        = len_x > cap_x;
    ov_b        = (fill_x + len_c) > cap_x;
  end

  always_comb begin
    rd_idx_next = rd_idx;
    wr_idx_next = wr_idx;
    cnt_next    = fill_x;
    ovr_next    = ovr;
    und_next    = und;
    noise_next  = noise;
    bu_next     = bu;
    rd_base     = rd_idx;
    cnt_base    = fill_x;
    under       = 1'b0;
    mem_en      = 1'b0;
    mem_we      = 1'b0;
    mem_addr    = rd_idx;
    mem_wdata   = sample;
    meta.src    = apjb_pkg::SRC_ZERO;
    meta.ok     = 1'b1;
    case (operation)
      apjb_pkg::OP_WRITE: begin
        if (chk) begin
          ovr_next = ovr + apjb_pkg::CNT_W'(ov_a) + apjb_pkg::CNT_W'(ov_b);
        end
        if (fill_x >= cap_x) begin
          rd_idx_next = wrap_inc(rd_idx);
          cnt_next    = cap_x;
        end else begin
          cnt_next = fill_x + XW'(1);
        end
        mem_en      = acc;
        mem_we      = 1'b1;
        mem_addr    = wr_idx;
        wr_idx_next = wrap_inc(wr_idx);
      end
      apjb_pkg::OP_READ: begin
        if (chk) begin
          rd_base  = rd_drained[IW-1:0];
          cnt_base = cnt_drained;
        end
        under = chk && (cnt_base < len_x);
        if (burst_start) begin
          bu_next = under;
        end
        und_next = und + apjb_pkg::CNT_W'(under);
        if (cnt_base != '0) begin
          mem_en      = acc;
          mem_addr    = rd_base;
          rd_idx_next = wrap_inc(rd_base);
          cnt_next    = cnt_base - XW'(1);
          meta.src    = apjb_pkg::SRC_MEM;
        end else begin
          rd_idx_next = rd_base;
          cnt_next    = cnt_base;
          noise_next  = noise * apjb_pkg::LCG_MUL + apjb_pkg::LCG_ADD;
          meta.src    = apjb_pkg::SRC_NOISE;
        end
        meta.ok = !bu_next;
      end
      apjb_pkg::OP_CLEAR: begin
        rd_idx_next = '0;
        wr_idx_next = '0;
        cnt_next    = '0;
        ovr_next    = '0;
        und_next    = '0;
      end
      default: begin
      end
    endcase
    fill_ext   = EW'(cnt_next[CW-1:0]);
    meta.fill  = fill_ext[apjb_pkg::FILL_W-1:0];
    meta.ovr   = ovr_next;
    meta.und   = und_next;
    meta.noise = noise_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
      wr_idx <= '0;
      count  <= '0;
      ovr    <= '0;
      und    <= '0;
      noise  <= '0;
      bu     <= 1'b0;
    end else if (acc) begin
      rd_idx <= rd_idx_next;
      wr_idx <= wr_idx_next;
      count  <= cnt_next[CW-1:0];
      ovr    <= ovr_next;
      und    <= und_next;
      noise  <= noise_next;
      bu     <= bu_next;
    end
  end

  // occupancy implied by the two indices
  logic [XW-1:0] span, cnt_mod;
  assign span    = (wr_idx >= rd_idx) ? XW'(wr_idx) - XW'(rd_idx)
                                      : XW'(wr_idx) + XW'(CAPACITY) - XW'(rd_idx);
  assign cnt_mod = (XW'(count) == XW'(CAPACITY)) ? '0 : XW'(count);

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    XW'(count) <= XW'(CAPACITY))
    else $error("fill above capacity");

  a_index_span: assert property (@(posedge clk) disable iff (rst)
    span == cnt_mod)
    else $error("indices disagree with fill");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    acc && operation == apjb_pkg::OP_CLEAR |=> count == '0 && ovr == '0 && und == '0)
    else $error("clear left state behind");

  a_write_fills: assert property (@(posedge clk) disable iff (rst)
    acc && operation == apjb_pkg::OP_WRITE |=> count != '0)
    else $error("write left store empty");

endmodule

/* src/apjb_resp.sv */
module apjb_resp (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       acc,
  input  apjb_pkg::meta_t            meta,
  input  logic [apjb_pkg::SMP_W-1:0] q,
  output logic                       take,
  apjb_res_if.source                 res
);

  logic            v1, v2, v3;
  logic            en1, en2, en3;
  apjb_pkg::meta_t m1, m2;
  logic [apjb_pkg::SMP_W-1:0] d2;
  logic [63:0]     prod2;

  logic signed [apjb_pkg::SMP_W-1:0] read_sample;
  logic                              burst_ok;
  logic [apjb_pkg::FILL_W-1:0]       fill_level;
  logic [apjb_pkg::CNT_W-1:0]        overrun_total, underrun_total;

  logic [apjb_pkg::RES_W-1:0] qm, qx, r0, r1;
  logic signed [apjb_pkg::SMP_W-1:0] noise_val, smp_next;

  assign en3  = !v3 || res.ready;
  assign en2  = !v2 || en3;
  assign en1  = !v1 || en2;
  assign take = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= acc;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  // store read data is valid while the item sits in stage 1
  always_ff @(posedge clk) begin
    if (en1 && acc) begin
      m1 <= meta;
    end
    if (en2 && v1) begin
      m2    <= m1;
      d2    <= q;
      prod2 <= 64'(m1.noise) * 64'(apjb_pkg::RECIP);
    end
  end

  always_comb begin
    qm = prod2[apjb_pkg::RECIP_SHIFT +: apjb_pkg::RES_W];
    qx = apjb_pkg::RES_W'(qm * apjb_pkg::RES_W'(apjb_pkg::NOISE_MOD));
    r0 = m2.noise[apjb_pkg::RES_W-1:0] - qx;
    r1 = (r0 >= apjb_pkg::RES_W'(apjb_pkg::NOISE_MOD))
         ? r0 - apjb_pkg::RES_W'(apjb_pkg::NOISE_MOD) : r0;
    noise_val = apjb_pkg::SMP_W'(r1) - apjb_pkg::SMP_W'(apjb_pkg::NOISE_OFS);
    case (m2.src)
      apjb_pkg::SRC_MEM:   smp_next = d2;
      apjb_pkg::SRC_NOISE: smp_next = noise_val;
      default:             smp_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      read_sample    <= smp_next;
      burst_ok       <= m2.ok;
      fill_level     <= m2.fill;
      overrun_total  <= m2.ovr;
      underrun_total <= m2.und;
    end
  end

  assign res.valid          = v3;
  assign res.read_sample    = read_sample;
  assign res.burst_ok       = burst_ok;
  assign res.fill_level     = fill_level;
  assign res.overrun_total  = overrun_total;
  assign res.underrun_total = underrun_total;

endmodule
